FILE: design/sbda_pkg.sv
package sbda_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MINUS,
        ST_DIGITS
    } sbda_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic emit_minus;
        logic emit_digit;
        logic skip_digit;
    } sbda_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic shift_done;
        logic negative;
        logic top_zero;
        logic ptr_zero;
        logic started;
        logic slot_free;
    } sbda_status_t;

endpackage

FILE: design/signed_binary_to_decimal_ascii_unit.sv
// signed binary to decimal ascii: one value in, its characters out one per transaction
// after acceptance all VALUE_BITS magnitude bits pass through the bit-serial double dabble loop; then
// a minus sign is sent for a negative value, and the digits follow most significant first, leading zeros
// dropped without a transaction, one digit per cycle while the output does not stall
// no new value is taken during a conversion; the next value is taken while the last character waits
// reset: rst_n is asynchronous active low and returns the unit to idle with no output pending
module signed_binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [6:0]                   char_code,
    output logic                         last_char
);

    sbda_pkg::sbda_cmd_t    cmd;
    sbda_pkg::sbda_status_t status;

    sbda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sbda_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

FILE: design/sbda_dp.sv
module sbda_dp #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  sbda_pkg::sbda_cmd_t          cmd,
    output sbda_pkg::sbda_status_t       status,
    output logic [6:0]                   char_code,
    output logic                         last_char,
    output logic                         out_valid,
    input  logic                         out_stall
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int PTR_W = $clog2(MAX_DIGITS);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic                  neg_reg;
    logic                  started_reg;
    logic                  out_valid_reg;
    logic [6:0]            char_reg;
    logic                  last_reg;

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] abs_value;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BCD_W-1:0]      bcd_shifted;
    logic [3:0]            top_nibble;

    assign value_u   = VALUE_BITS'(value);
    // most negative value wraps to its own bit pattern, which is the true magnitude
    assign abs_value = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

    // add 3 to every digit of five or more, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
        bcd_shifted = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
    end

    assign top_nibble = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        status.shift_done = (cnt_reg == CNT_W'(VALUE_BITS - 1));
        status.negative   = neg_reg;
        status.top_zero   = (top_nibble == 4'd0);
        status.ptr_zero   = (ptr_reg == '0);
        status.started    = started_reg;
        status.slot_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= abs_value;
            bcd_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= value_u[VALUE_BITS-1];
            ptr_reg <= PTR_W'(MAX_DIGITS - 1);
        end
        else if (cmd.shift)
        begin
            mag_reg <= mag_reg << 1;
            bcd_reg <= bcd_shifted;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.emit_digit || cmd.skip_digit)
        begin
            bcd_reg <= bcd_reg << 4;
            ptr_reg <= ptr_reg - PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                started_reg <= 1'b0;
            end
            else if (cmd.emit_digit)
            begin
                started_reg <= 1'b1;
            end

            if (cmd.emit_minus || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_minus)
        begin
            char_reg <= sbda_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sbda_pkg::CHAR_ZERO + {3'b000, top_nibble};
            last_reg <= (ptr_reg == '0);
        end
    end

    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |=> out_valid_reg && (char_reg >= sbda_pkg::CHAR_ZERO)
            && (char_reg <= sbda_pkg::CHAR_ZERO + 7'd9))
        else $error("digit transaction carries a non-digit code");
    a_skip_leading: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip_digit |-> !started_reg && (ptr_reg != '0) && (top_nibble == 4'd0))
        else $error("skipped a digit that is not a leading zero");
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (bcd_reg == '0) && (cnt_reg == '0) && !started_reg)
        else $error("conversion did not start from a cleared state");
`endif

endmodule

FILE: design/sbda_ctrl.sv
module sbda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sbda_pkg::sbda_status_t status,
    output sbda_pkg::sbda_cmd_t    cmd
);

    sbda_pkg::sbda_state_t state_reg;
    sbda_pkg::sbda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sbda_pkg::ST_SHIFT;
                end
            end
            sbda_pkg::ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.shift_done)
                begin
                    state_next = status.negative ? sbda_pkg::ST_MINUS : sbda_pkg::ST_DIGITS;
                end
            end
            sbda_pkg::ST_MINUS:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_minus = 1'b1;
                    state_next     = sbda_pkg::ST_DIGITS;
                end
            end
            sbda_pkg::ST_DIGITS:
            begin
                // leading zeros are dropped without using the output slot
                if (status.top_zero && !status.started && !status.ptr_zero)
                begin
                    cmd.skip_digit = 1'b1;
                end
                else if (status.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.ptr_zero)
                    begin
                        state_next = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_shift_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbda_pkg::ST_SHIFT) && !status.shift_done
            |=> state_reg == sbda_pkg::ST_SHIFT)
        else $error("left shifting before all bits were taken");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [6:0]         char_code;
    logic               last_char;

    logic rx_stall;
    logic hold_stall;
    logic tx_fast;
    logic rx_fast;
    int   hold_req;
    int   errors;
    int   cycles;

    text_char_t expected_chars[$];

    assign out_stall = rx_stall | hold_stall;

    signed_binary_to_decimal_ascii_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_code(char_code),
        .last_char(last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // expected decimal text of one value, most significant character first
    function automatic void push_decimal_text(input logic signed [31:0] v);
        logic [32:0] mag;
        logic [3:0]  digits [10];
        text_char_t  c;
        int          top;
        int          i;
        // 33 bits so the most negative value keeps its true magnitude
        mag = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
        for (i = 0; i < 10; i++)
        begin
            digits[i] = 4'(mag % 10);
            mag = mag / 10;
        end
        top = 0;
        for (i = 9; i > 0; i--)
        begin
            if (digits[i] != 0 && top == 0)
                top = i;
        end
        if (v[31])
        begin
            c.code = sbda_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (i = top; i >= 0; i--)
        begin
            c.code = sbda_pkg::CHAR_ZERO + 7'(digits[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // receiver: random stall before each character unless rx_fast is set, then check it
    initial
    begin
        int         wait_left;
        text_char_t want;
        wait_left = 0;
        forever
        begin
            @(negedge clk);
            rx_stall <= (wait_left > 0);
            if (wait_left > 0)
                wait_left--;
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected char_code", char_code, 0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code)
                        report_mismatch("char_code", char_code, want.code);
                    if (last_char !== want.last)
                        report_mismatch("last_char", last_char, want.last);
                end
                wait_left = rx_fast ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // long output hold-off, counted here so the sender keeps offering values
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req = 0;
                repeat (n)
                begin
                    hold_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_stall <= 1'b0;
            end
        end
    end

    task automatic send_value(input logic signed [31:0] v);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        push_decimal_text(v);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        longint p;
        longint v;
        int     k;
        case ($urandom_range(0, 3))
            0: v = longint'($signed($urandom));
            1: v = $urandom_range(0, 20);
            2:
            begin
                // around a power of ten, where the digit count changes
                p = 1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            default:
            begin
                p = 1;
                k = $urandom_range(1, 10);
                repeat (k) p = p * 10;
                v = longint'($urandom) % p;
            end
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return 32'(v);
    endfunction

    task automatic test_directed();
        logic signed [31:0] vals [$];
        vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
                 32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
                 32'sd999999999, -32'sd999999999, 32'sd1234567890, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'sd7, -32'sd5, 32'hFFFF_FFFE};
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random();
        int chunk;
        for (chunk = 0; chunk < 4; chunk++)
        begin
            // first stretch runs with no idling on either side
            tx_fast = (chunk == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            rx_fast = (chunk == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            repeat (18)
                send_value(rand_value());
        end
    endtask

    task automatic test_output_hold();
        tx_fast = 1'b1;
        rx_fast = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (10)
            send_value(rand_value());
    endtask

    task automatic test_sender_pause();
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        repeat (5)
            send_value(rand_value());
        wait_drain();
        repeat (5)
            send_value(rand_value());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        rx_stall   = 1'b0;
        hold_stall = 1'b0;
        tx_fast    = 1'b0;
        rx_fast    = 1'b0;
        hold_req   = 0;
        errors     = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();
        test_output_hold();
        test_sender_pause();

        wait_drain();
        repeat (60) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch("characters missing", 0, expected_chars.size());
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
